@@ rtl/assert_macros.svh @@
// Assertion macros for the barometer compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on clk, off while arst_n is low
`define BC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on clk at every edge, reset included
`define BC_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BC_ASSERT(lbl, prop, msg)
`define BC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ rtl/bc_pkg.sv @@
// Shared types, widths and constants of the barometer compensation block.
package bc_pkg;

	// field widths
	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int TEMP_W    = 19;
	localparam int PRES_W    = 23;
	localparam int CFG_IDX_W = 3;

	// internal datapath widths
	localparam int DT_W      = 25;
	localparam int PM_W      = 42;
	localparam int OFF_W     = 36;
	localparam int SENS_W    = 35;
	localparam int SENS_LO_W = 17;
	localparam int PL_W      = RAW_W + SENS_LO_W;
	localparam int PH_W      = RAW_W + 1 + SENS_W - SENS_LO_W;
	localparam int PROD_W    = 60;
	localparam int DIFF_W    = 40;
	localparam int WIDE_W    = 64;

	// pipeline depth
	localparam int NUM_STAGES = 7;
	localparam int S_LAST     = NUM_STAGES - 1;

	// scaling constants
	localparam logic [TEMP_W-1:0] TEMP_BASE = 19'd2000;
	localparam logic [4:0] SH_TEMP    = 5'd23;
	localparam logic [4:0] SH_OFF_V0  = 5'd6;
	localparam logic [4:0] SH_OFF_V1  = 5'd7;
	localparam logic [4:0] SH_SENS_V0 = 5'd7;
	localparam logic [4:0] SH_SENS_V1 = 5'd8;
	localparam logic [4:0] SH_PROD    = 5'd21;
	localparam logic [4:0] SH_PRES    = 5'd15;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFF_BASE    = 3'd1,
		REG_SENS_TEMPCO = 3'd2,
		REG_OFF_TEMPCO  = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5,
		REG_VARIANT     = 3'd6
	} reg_idx_t;

	// calibration register contents
	typedef struct packed {
		logic [CAL_W-1:0] sens_base;
		logic [CAL_W-1:0] off_base;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] off_tempco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_slope;
		logic             variant;
	} cfg_t;

	// per-stage load enables and valid bits
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

	// coefficients handed from the front stages to the pressure stages
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} front_t;

	// signed division by 2^sh, truncating toward zero
	function automatic logic signed [WIDE_W-1:0] sdiv_pow2(
		input logic signed [WIDE_W-1:0] x,
		input logic [4:0] sh
	);
		logic signed [WIDE_W-1:0] bias;
		bias = x[WIDE_W-1] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage

@@ rtl/bc_if.sv @@
// Valid/ready channel interfaces for raw samples and compensated results.
interface bc_in_if;
	import bc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	modport source(output valid, raw_pressure, raw_temperature, input ready);
	modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bc_out_if;
	import bc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_centi;
	logic signed [PRES_W-1:0] pressure_comp;
	modport source(output valid, temp_centi, pressure_comp, input ready);
	modport sink(input valid, temp_centi, pressure_comp, output ready);
endinterface

@@ rtl/bc_cfg_regs.sv @@
// Calibration register file with a plain write port.
module bc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bc_pkg::CAL_W-1:0]      cfg_wdata,
	output bc_pkg::cfg_t                  cfg
);
	import bc_pkg::*;

	cfg_t cfg_q;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SENS_BASE:   cfg_q.sens_base   <= cfg_wdata;
				REG_OFF_BASE:    cfg_q.off_base    <= cfg_wdata;
				REG_SENS_TEMPCO: cfg_q.sens_tempco <= cfg_wdata;
				REG_OFF_TEMPCO:  cfg_q.off_tempco  <= cfg_wdata;
				REG_REF_TEMP:    cfg_q.ref_temp    <= cfg_wdata;
				REG_TEMP_SLOPE:  cfg_q.temp_slope  <= cfg_wdata;
				REG_VARIANT:     cfg_q.variant     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/bc_pipe_ctl.sv @@
// Valid bits and per-stage load enables of the compensation pipeline.
module bc_pipe_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	output bc_pkg::pipe_ctl_t ctl
);
	import bc_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] load;

	// a stage loads when empty or when the next one moves on
	always_comb begin
		load[S_LAST] = !valid_q[S_LAST] || out_ready;
		for (int k = S_LAST - 1; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) valid_q[0] <= in_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	assign ctl.load  = load;
	assign ctl.valid = valid_q;

endmodule

@@ rtl/bc_front.sv @@
// Stages 1-3: temperature difference, coefficient products, TEMP/OFF/SENS.
module bc_front (
	input  logic                     clk,
	input  bc_pkg::pipe_ctl_t        ctl,
	input  bc_pkg::cfg_t             cfg,
	input  logic [bc_pkg::RAW_W-1:0] raw_pressure,
	input  logic [bc_pkg::RAW_W-1:0] raw_temperature,
	output bc_pkg::front_t           front
);
	import bc_pkg::*;

	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0]       d1_s1;
	logic signed [PM_W-1:0] mt_s2, mo_s2, ms_s2;
	logic [RAW_W-1:0]       d1_s2;
	front_t                 front_s3;

	logic signed [WIDE_W-1:0] t_div, o_div, s_div;
	logic [4:0]               o_sh, s_sh;
	logic [OFF_W-1:0]         off_base;
	logic [SENS_W-1:0]        sens_base;
	front_t                   front_nx;

	// stage 1: dT = D2 - C5*256
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'b0});
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: three 25x17 products
	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			mt_s2 <= dt_s1 * $signed({1'b0, cfg.temp_slope});
			mo_s2 <= dt_s1 * $signed({1'b0, cfg.off_tempco});
			ms_s2 <= dt_s1 * $signed({1'b0, cfg.sens_tempco});
			d1_s2 <= d1_s1;
		end
	end

	// stage 3: scale products, add base terms per variant
	always_comb begin
		o_sh      = cfg.variant ? SH_OFF_V1 : SH_OFF_V0;
		s_sh      = cfg.variant ? SH_SENS_V1 : SH_SENS_V0;
		t_div     = sdiv_pow2(WIDE_W'(mt_s2), SH_TEMP);
		o_div     = sdiv_pow2(WIDE_W'(mo_s2), o_sh);
		s_div     = sdiv_pow2(WIDE_W'(ms_s2), s_sh);
		off_base  = cfg.variant ? OFF_W'({cfg.off_base, 16'b0}) : OFF_W'({cfg.off_base, 17'b0});
		sens_base = cfg.variant ? SENS_W'({cfg.sens_base, 15'b0})
			: SENS_W'({cfg.sens_base, 16'b0});
		front_nx.d1   = d1_s2;
		front_nx.temp = $signed(t_div[TEMP_W-1:0] + TEMP_BASE);
		front_nx.off  = $signed(off_base) + $signed(o_div[OFF_W-1:0]);
		front_nx.sens = $signed(sens_base) + $signed(s_div[SENS_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) front_s3 <= front_nx;
	end

	assign front = front_s3;

endmodule

@@ rtl/bc_press.sv @@
// Stages 4-7: D1*SENS in two partial products, then the pressure formula.
module bc_press (
	input  logic                             clk,
	input  bc_pkg::pipe_ctl_t                ctl,
	input  bc_pkg::front_t                   front,
	output logic signed [bc_pkg::TEMP_W-1:0] temp_centi,
	output logic signed [bc_pkg::PRES_W-1:0] pressure_comp
);
	import bc_pkg::*;

	logic [PL_W-1:0]            pl_s4;
	logic signed [PH_W-1:0]     ph_s4;
	logic signed [OFF_W-1:0]    off_s4, off_s5;
	logic signed [TEMP_W-1:0]   temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [PROD_W-1:0]   prod_s5;
	logic signed [DIFF_W-1:0]   diff_s6;
	logic signed [PRES_W-1:0]   pres_s7;
	logic signed [WIDE_W-1:0]   q_div, p_div;

	// stage 4: low part unsigned 24x17, high part signed 25x18
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			pl_s4   <= front.d1 * front.sens[SENS_LO_W-1:0];
			ph_s4   <= $signed({1'b0, front.d1}) * $signed(front.sens[SENS_W-1:SENS_LO_W]);
			off_s4  <= front.off;
			temp_s4 <= front.temp;
		end
	end

	// stage 5: recombine the full product
	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			prod_s5 <= $signed({ph_s4, {SENS_LO_W{1'b0}}})
				+ $signed({{(PROD_W - PL_W){1'b0}}, pl_s4});
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
		end
	end

	// stage 6: D1*SENS/2^21 - OFF
	assign q_div = sdiv_pow2(WIDE_W'(prod_s5), SH_PROD);

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			diff_s6 <= $signed(q_div[DIFF_W-1:0]) - DIFF_W'(off_s5);
			temp_s6 <= temp_s5;
		end
	end

	// stage 7: final /2^15, output register
	assign p_div = sdiv_pow2(WIDE_W'(diff_s6), SH_PRES);

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			pres_s7 <= $signed(p_div[PRES_W-1:0]);
			temp_s7 <= temp_s6;
		end
	end

	assign temp_centi    = temp_s7;
	assign pressure_comp = pres_s7;

endmodule

@@ rtl/barometer_compensation.sv @@
// Barometer first-order compensation, seven-stage pipeline.
// An accepted sample passes through the stage 1 to stage 7 registers; stage 7 is the output register.
// Throughput: one sample per cycle while the output is not stalled; the D1*SENS product is split over two stages.
// A stalled output holds the last stage; earlier stages keep filling their bubbles.
// arst_n clears all valid bits and calibration registers to zero; data regs are not reset.
module barometer_compensation (
	input  logic                         clk,
	input  logic                         arst_n,
	bc_in_if.sink                        sample,
	bc_out_if.source                     result,
	input  logic                         cfg_we,
	input  logic [bc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bc_pkg::CAL_W-1:0]     cfg_wdata
);
	import bc_pkg::*;

	`include "assert_macros.svh"

	cfg_t                     cfg;
	pipe_ctl_t                ctl;
	front_t                   front;
	logic signed [TEMP_W-1:0] temp_centi;
	logic signed [PRES_W-1:0] pressure_comp;

	bc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.out_ready (result.ready),
		.ctl       (ctl)
	);

	bc_front u_front (
		.clk             (clk),
		.ctl             (ctl),
		.cfg             (cfg),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.front           (front)
	);

	bc_press u_press (
		.clk           (clk),
		.ctl           (ctl),
		.front         (front),
		.temp_centi    (temp_centi),
		.pressure_comp (pressure_comp)
	);

	// channel hookup
	assign sample.ready         = ctl.load[0];
	assign result.valid         = ctl.valid[S_LAST];
	assign result.temp_centi    = temp_centi;
	assign result.pressure_comp = pressure_comp;

	// an accepted transaction lands in stage 1
	`BC_ASSERT(a_accept_fills_s1, sample.valid && sample.ready |=> ctl.valid[0], "accepted transaction lost at stage 1")
	// input is refused only when every stage holds an item
	`BC_ASSERT(a_refuse_when_full, !sample.ready |-> (&ctl.valid), "input stalled with a bubble in the pipeline")
	// compensated temperature stays within its defined span
	`BC_ASSERT_NR(a_temp_span, result.valid |-> (($signed(result.temp_centi) >= -32'sd129068) && ($signed(result.temp_centi) <= 32'sd133069)), "temperature out of span")

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the barometer compensation pipeline.
`timescale 1ns / 1ps

module tb_top;
	import bc_pkg::*;

	localparam int  CLK_HALF          = 5;
	localparam int  CYCLE_LIMIT       = 100000;
	localparam int  SETTLE_CYCLES     = NUM_STAGES + 3;
	localparam int  NUM_PHASES        = 8;
	localparam int  PHASE_ITEMS       = 100;
	localparam int  LONG_STALL_CYCLES = 300;
	localparam int  DIR_ROWS          = 34;
	localparam int  RAW_MAX           = (1 << RAW_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register behind this index

	typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centi;
		logic signed [PRES_W-1:0] pressure_comp;
	} reading_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CAL_W-1:0]       wdata;
		logic [RAW_W-1:0]       d1;
		logic [RAW_W-1:0]       d2;
		bit                     typed;
		reading_t               want;
	} dir_row_t;

	// calibration registers in write order for random phases
	localparam reg_idx_t CAL_REGS [6] = '{REG_SENS_BASE, REG_OFF_BASE, REG_SENS_TEMPCO,
		REG_OFF_TEMPCO, REG_REF_TEMP, REG_TEMP_SLOPE};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_wdata;

	bc_in_if  sample_ch();
	bc_out_if result_ch();

	barometer_compensation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of the calibration registers
	cfg_t cal = '0;
	reading_t pending_readings[$];

	int mismatches = 0;
	int results_checked = 0;
	int readings_sent = 0;
	int cfg_writes = 0;
	int backpressure_cycles = 0;
	int cycle_count = 0;
	int send_idle_pct = 20;
	int recv_idle_pct = 81;
	bit receiver_held = 1'b0;
	event long_stall_start;

	// directed stimulus: reset values, extremes, both variants, register corner cases
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h000000, 24'h000000, 1'b1, '{19'sd2000, 23'sd0}},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{19'sd2000, 23'sd0}},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'h000000, 1'b1, '{19'sd2000, 23'sd0}},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h000000, 24'hFFFFFF, 1'b1, '{19'sd2000, 23'sd0}},
		'{ROW_CFG, REG_SENS_BASE,   16'd40127, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_OFF_BASE,    16'd36924, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_SENS_TEMPCO, 16'd23317, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_OFF_TEMPCO,  16'd23282, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_REF_TEMP,    16'd33464, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_TEMP_SLOPE,  16'd28312, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'd9085466, 24'd8569150, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h000000, 24'h000000, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
		'{ROW_CFG, REG_VARIANT,     16'h0001, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'd9085466, 24'd8569150, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
		'{ROW_CFG, REG_SENS_BASE,   16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_OFF_BASE,    16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_SENS_TEMPCO, 16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_OFF_TEMPCO,  16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_REF_TEMP,    16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_CFG, REG_TEMP_SLOPE,  16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h000000, 24'hFFFFFF, 1'b0, '0},
		// upper bits of the variant word are dropped: this selects variant 0
		'{ROW_CFG, REG_VARIANT,     16'hFFFE, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
		// write to an unused index must leave every register alone
		'{ROW_CFG, REG_NONE,        16'hFFFF, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h800000, 24'h7FFFFF, 1'b0, '0},
		'{ROW_CFG, REG_REF_TEMP,    16'h0000, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
		'{ROW_CFG, REG_SENS_BASE,   16'h0000, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_SAMPLE, REG_SENS_BASE, 16'h0, 24'h555555, 24'hAAAAAA, 1'b0, '0}
	};

	always #CLK_HALF clk = ~clk;

	// first-order compensation, exact integer math, divisions truncate toward zero
	function automatic reading_t compensate_reading(input logic [RAW_W-1:0] raw_p,
			input logic [RAW_W-1:0] raw_t, input cfg_t c);
		longint d1, dt, temp, off, sens, pres;
		reading_t r;
		d1 = longint'(raw_p);
		dt = longint'(raw_t) - longint'(c.ref_temp) * 256;
		temp = 2000 + (dt * longint'(c.temp_slope)) / 8388608;
		if (!c.variant) begin
			off  = longint'(c.off_base) * 131072 + (longint'(c.off_tempco) * dt) / 64;
			sens = longint'(c.sens_base) * 65536 + (longint'(c.sens_tempco) * dt) / 128;
		end else begin
			off  = longint'(c.off_base) * 65536 + (longint'(c.off_tempco) * dt) / 128;
			sens = longint'(c.sens_base) * 32768 + (longint'(c.sens_tempco) * dt) / 256;
		end
		pres = ((d1 * sens) / 2097152 - off) / 32768;
		r.temp_centi    = temp[TEMP_W-1:0];
		r.pressure_comp = pres[PRES_W-1:0];
		return r;
	endfunction

	// raw field with extra weight on both ends of the range
	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom_range(RAW_MAX));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR: result %0d, %s: got %0d, expected %0d",
			results_checked, what, got, want);
		mismatches++;
	endtask

	// register write, mirrored into the predictor copy
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_SENS_BASE:   cal.sens_base   = data;
			REG_OFF_BASE:    cal.off_base    = data;
			REG_SENS_TEMPCO: cal.sens_tempco = data;
			REG_OFF_TEMPCO:  cal.off_tempco  = data;
			REG_REF_TEMP:    cal.ref_temp    = data;
			REG_TEMP_SLOPE:  cal.temp_slope  = data;
			REG_VARIANT:     cal.variant     = data[0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	// offer one sample pair; expectation is queued at the accepting edge
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
			input bit typed, input reading_t want);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.raw_pressure    <= d1;
		sample_ch.raw_temperature <= d2;
		do @(posedge clk); while (!sample_ch.ready);
		pending_readings.push_back(typed ? want : compensate_reading(d1, d2, cal));
		readings_sent++;
	endtask

	// stop offering and let the pipeline empty
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		cfg_we          <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result checking and receiver ready
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n) begin
			if (sample_ch.valid && !sample_ch.ready)
				backpressure_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				if (pending_readings.size() == 0) begin
					report_mismatch("transaction with nothing expected",
						result_ch.temp_centi, 0);
				end else begin
					want = pending_readings.pop_front();
					if (result_ch.temp_centi !== want.temp_centi)
						report_mismatch("temp_centi", result_ch.temp_centi, want.temp_centi);
					if (result_ch.pressure_comp !== want.pressure_comp)
						report_mismatch("pressure_comp", result_ch.pressure_comp,
							want.pressure_comp);
					results_checked++;
				end
			end
		end
		result_ch.ready <= !receiver_held && ($urandom_range(99) >= recv_idle_pct);
	end

	// long receiver hold-off, counted here
	always begin
		@(long_stall_start);
		@(posedge clk);
		receiver_held <= 1'b1;
		repeat (LONG_STALL_CYCLES) @(posedge clk);
		receiver_held <= 1'b0;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TIMEOUT after %0d cycles, %0d results outstanding",
			cycle_count, pending_readings.size());
		$display("barometer_compensation test failed");
		$finish;
	end

	// main sequence
	initial begin
		logic [RAW_W-1:0] d1, d2;
		logic [CAL_W-1:0] v;
		int near;
		int directed_count;

		arst_n                    = 1'b0;
		cfg_we                    = 1'b0;
		cfg_index                 = '0;
		cfg_wdata                 = '0;
		sample_ch.valid           = 1'b0;
		sample_ch.raw_pressure    = '0;
		sample_ch.raw_temperature = '0;
		result_ch.ready           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_drained();
				program_reg(directed_rows[i].index, directed_rows[i].wdata);
			end else begin
				send_reading(directed_rows[i].d1, directed_rows[i].d2,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end
		directed_count = readings_sent;

		// random phases, each under its own calibration
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 3) begin
				send_idle_pct = 81;
				recv_idle_pct = 20;
			end else if (phase == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_drained();
			foreach (CAL_REGS[r]) begin
				if (phase == 0)
					v = '1;
				else if (phase == 1)
					v = '0;
				else
					case ($urandom_range(3))
						0: v = '0;
						1: v = '1;
						default: v = CAL_W'($urandom_range(16'hFFFF));
					endcase
				program_reg(CAL_REGS[r], v);
			end
			// full word, random after the first two phases, so the dropped upper bits toggle too
			program_reg(REG_VARIANT, (phase == 0) ? 16'hFFFF :
				(phase == 1) ? 16'h0000 : 16'($urandom));
			if (phase % 3 == 2)
				program_reg(REG_NONE, 16'($urandom));

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver stops while the sender keeps offering
				if (phase == 6 && n == 0)
					-> long_stall_start;
				// sender pauses until everything outstanding has come back
				if (phase == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				d1 = pick_raw();
				if ($urandom_range(3) == 0) begin
					// temperature near the reference, dT around zero
					near = int'(cal.ref_temp) * 256 + int'($urandom_range(1024)) - 512;
					d2 = (near < 0) ? '0 : (near > RAW_MAX) ? RAW_W'(RAW_MAX) : RAW_W'(near);
				end else begin
					d2 = pick_raw();
				end
				send_reading(d1, d2, 1'b0, '0);
			end
		end

		wait_drained();
		$display("Covered %0d sample pairs (%0d directed) over %0d register writes,",
			readings_sent, directed_count, cfg_writes);
		$display("both variants and extremes; %0d results checked, %0d input stall cycles.",
			results_checked, backpressure_cycles);
		if (mismatches == 0)
			$display("barometer_compensation test passed");
		else
			$display("barometer_compensation test failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bc_pkg.sv
rtl/bc_if.sv
rtl/bc_cfg_regs.sv
rtl/bc_pipe_ctl.sv
rtl/bc_front.sv
rtl/bc_press.sv
rtl/barometer_compensation.sv
tb/sv/tb_top.sv
